/* src/tlfg_pkg.sv */
package tlfg_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int DividendWidth = 35;
  localparam int DivisorWidth  = 17;

  typedef struct packed {
    logic               op;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [17:0] d0;
    logic signed [17:0] d1;
    logic [31:0]        color;
    logic [1:0]         half;
    logic [16:0]        adx;
    logic [16:0]        ady;
    logic               neg_x;
    logic               neg_y;
    logic               reject;
  } line_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV_START,
    BK_DIV,
    BK_SUM,
    BK_EMIT
  } back_state_t;

  // Largest |ox| inside the round brush for a given brush half width and |oy|.
  function automatic logic [1:0] brush_reach(input logic [1:0] half, input logic [1:0] ay);
    logic [1:0] r;
    r = 2'd0;
    unique case ({half, ay})
      4'b01_00, 4'b01_01:             r = 2'd1;
      4'b10_00, 4'b10_01:             r = 2'd2;
      4'b10_10:                       r = 2'd1;
      4'b11_00, 4'b11_01:             r = 2'd3;
      4'b11_10:                       r = 2'd2;
      4'b11_11:                       r = 2'd1;
      default:                        r = 2'd0;
    endcase
    return r;
  endfunction

  // Q1.8 alpha fade factor by brush half width and squared distance.
  function automatic logic [8:0] edge_factor(input logic [1:0] half, input logic [3:0] d2);
    logic [8:0] f;
    f = 9'd0;
    unique case ({half, d2})
      6'b10_0000: f = 9'd256;
      6'b10_0001: f = 9'd162;
      6'b10_0010: f = 9'd124;
      6'b10_0100: f = 9'd69;
      6'b10_0101: f = 9'd47;
      6'b11_0000: f = 9'd256;
      6'b11_0001: f = 9'd187;
      6'b11_0010: f = 9'd159;
      6'b11_0100: f = 9'd119;
      6'b11_0101: f = 9'd103;
      6'b11_1000: f = 9'd62;
      6'b11_1001: f = 9'd51;
      6'b11_1010: f = 9'd40;
      default:    f = 9'd256;
    endcase
    return f;
  endfunction

endpackage

/* src/tlfg_front.sv */
module tlfg_front #(
  parameter int MAX_BRUSH_HALF = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [12:0]           cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [143:0]          s_axis_tdata,
  input  logic                  s_axis_tuser,
  output tlfg_pkg::line_cmd_t   cmd,
  output logic                  cmd_valid,
  input  logic                  cmd_ready
);

  logic [12:0] frame_width;
  logic [12:0] frame_height;

  tlfg_pkg::line_cmd_t incoming;
  tlfg_pkg::line_cmd_t queue [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;
  logic                pop;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [2:0]         wh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tlfg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        tlfg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    incoming.op     = s_axis_tuser;
    incoming.x0     = s_axis_tdata[15:0];
    incoming.y0     = s_axis_tdata[31:16];
    incoming.x1     = s_axis_tdata[47:32];
    incoming.y1     = s_axis_tdata[63:48];
    incoming.d0     = s_axis_tdata[81:64];
    incoming.d1     = s_axis_tdata[99:82];
    incoming.color  = s_axis_tdata[131:100];
    dx = {incoming.x1[15], incoming.x1} - {incoming.x0[15], incoming.x0};
    dy = {incoming.y1[15], incoming.y1} - {incoming.y0[15], incoming.y0};
    incoming.adx   = dx[16] ? 17'(-dx) : 17'(dx);
    incoming.ady   = dy[16] ? 17'(-dy) : 17'(dy);
    incoming.neg_x = dx[16] || (dx == 17'sd0);
    incoming.neg_y = dy[16] || (dy == 17'sd0);
    wh = s_axis_tdata[139:137];
    if (wh == 3'd0) begin
      incoming.half = 2'd1;
    end else if (wh > 3'(MAX_BRUSH_HALF)) begin
      incoming.half = 2'(MAX_BRUSH_HALF);
    end else begin
      incoming.half = wh[1:0];
    end
    incoming.reject = (incoming.adx > {2'b00, frame_width, 2'b00})
                   || (incoming.ady > {2'b00, frame_height, 2'b00})
                   || (!incoming.d0[17] && incoming.d0[16]
                       && !incoming.d1[17] && incoming.d1[16]);
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (count != 2'd0);
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* src/tlfg_div.sv */
module tlfg_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [tlfg_pkg::DividendWidth-1:0]   dividend,
  input  logic [tlfg_pkg::DivisorWidth-1:0]    divisor,
  output logic                                 done,
  output logic [tlfg_pkg::DividendWidth-1:0]   quotient
);

  localparam int CountWidth = $clog2(tlfg_pkg::DividendWidth + 1);

  logic [tlfg_pkg::DivisorWidth-1:0] remainder;
  logic [tlfg_pkg::DivisorWidth:0]   trial;
  logic [CountWidth-1:0]             count;
  logic                              busy;

  assign trial = {remainder, quotient[tlfg_pkg::DividendWidth-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        remainder <= tlfg_pkg::DivisorWidth'(trial - {1'b0, divisor});
        quotient  <= {quotient[tlfg_pkg::DividendWidth-2:0], 1'b1};
      end else begin
        remainder <= trial[tlfg_pkg::DivisorWidth-1:0];
        quotient  <= {quotient[tlfg_pkg::DividendWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CountWidth'(tlfg_pkg::DividendWidth);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CountWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/tlfg_back.sv */
module tlfg_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlfg_pkg::line_cmd_t  cmd,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [87:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int SumWidth = (COORD_WIDTH > 17) ? COORD_WIDTH : 17;

  tlfg_pkg::back_state_t state;
  tlfg_pkg::back_state_t state_next;

  logic signed [15:0] current_x;
  logic signed [15:0] current_y;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic               step_sign_x;
  logic               step_sign_y;
  logic [16:0]        span_x;
  logic signed [17:0] span_y_neg;
  logic signed [18:0] error_term;
  logic [16:0]        total_steps;
  logic [16:0]        step_index;
  logic signed [17:0] depth_a;
  logic signed [17:0] depth_b;
  logic [31:0]        line_color;
  logic [1:0]         brush_half;
  logic               line_active;

  logic signed [36:0] product;
  logic [18:0]        quot;
  logic signed [17:0] depth;
  logic signed [2:0]  ox;
  logic signed [2:0]  oy;

  logic [31:0] out_x;
  logic [0:0]  out_unused;
  logic [15:0] out_px;
  logic [15:0] out_py;
  logic [17:0] out_depth;
  logic [31:0] out_color;
  logic        out_blend;
  logic        out_fin;

  logic                                div_start;
  logic                                div_done;
  logic [tlfg_pkg::DividendWidth-1:0]  div_quotient;
  logic [36:0]                         prod_mag;

  logic signed [18:0] diff;
  logic signed [18:0] quot_signed;
  logic               fire;
  logic               done_point;
  logic               last_frag;
  logic [1:0]         oy_abs;
  logic [1:0]         ox_abs;
  logic [1:0]         reach;
  logic signed [2:0]  oy_inc;
  logic [1:0]         oy_inc_abs;
  logic [1:0]         reach_inc;
  logic [4:0]         d2;
  logic [16:0]        alpha_prod;
  logic [7:0]         alpha;
  logic signed [SumWidth-1:0]    sum_x;
  logic signed [SumWidth-1:0]    sum_y;
  logic signed [COORD_WIDTH-1:0] wrap_x;
  logic signed [COORD_WIDTH-1:0] wrap_y;
  logic signed [SumWidth-1:0]    ext_x;
  logic signed [SumWidth-1:0]    ext_y;
  logic signed [19:0]            e2;
  logic                          take_x;
  logic                          take_y;

  assign out_unused    = 1'b0;
  assign out_x         = {out_py, out_px};
  assign m_axis_tdata  = {out_unused, 5'd0, out_color, out_depth, out_x};
  assign m_axis_tuser  = {out_fin, out_blend};

  tlfg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag[tlfg_pkg::DividendWidth-1:0]),
    .divisor  (total_steps),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    diff        = {depth_b[17], depth_b} - {depth_a[17], depth_a};
    prod_mag    = product[36] ? 37'(-product) : 37'(product);
    quot_signed = product[36] ? 19'(-$signed(quot)) : $signed(quot);
    done_point  = (current_x == target_x) && (current_y == target_y);
    fire        = !m_axis_tvalid || m_axis_tready;

    oy_abs     = oy[2] ? 2'(-oy) : oy[1:0];
    ox_abs     = ox[2] ? 2'(-ox) : ox[1:0];
    reach      = tlfg_pkg::brush_reach(brush_half, oy_abs);
    oy_inc     = oy + 3'sd1;
    oy_inc_abs = oy_inc[2] ? 2'(-oy_inc) : oy_inc[1:0];
    reach_inc  = tlfg_pkg::brush_reach(brush_half, oy_inc_abs);
    last_frag  = (oy == $signed({1'b0, brush_half})) && (ox == $signed({1'b0, reach}));

    d2         = 5'(ox_abs * ox_abs) + 5'(oy_abs * oy_abs);
    alpha_prod = line_color[7:0] * tlfg_pkg::edge_factor(brush_half, d2[3:0]);
    alpha      = (brush_half > 2'd1) ? alpha_prod[15:8] : line_color[7:0];

    sum_x  = SumWidth'(current_x) + SumWidth'(ox);
    sum_y  = SumWidth'(current_y) + SumWidth'(oy);
    wrap_x = sum_x[COORD_WIDTH-1:0];
    wrap_y = sum_y[COORD_WIDTH-1:0];
    ext_x  = SumWidth'(wrap_x);
    ext_y  = SumWidth'(wrap_y);

    e2     = {error_term[18], error_term} <<< 1;
    take_x = e2 >= 20'(span_y_neg);
    take_y = e2 <= $signed({3'b000, span_x});
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      tlfg_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid && (cmd.op == tlfg_pkg::OP_STEP) && line_active) begin
          state_next = tlfg_pkg::BK_MUL;
        end
      end
      tlfg_pkg::BK_MUL: state_next = tlfg_pkg::BK_DIV_START;
      tlfg_pkg::BK_DIV_START: begin
        if (total_steps == 17'd0) begin
          state_next = tlfg_pkg::BK_SUM;
        end else begin
          div_start  = 1'b1;
          state_next = tlfg_pkg::BK_DIV;
        end
      end
      tlfg_pkg::BK_DIV: begin
        if (div_done) begin
          state_next = tlfg_pkg::BK_SUM;
        end
      end
      tlfg_pkg::BK_SUM: state_next = tlfg_pkg::BK_EMIT;
      tlfg_pkg::BK_EMIT: begin
        if (fire && last_frag) begin
          state_next = tlfg_pkg::BK_IDLE;
        end
      end
      default: state_next = tlfg_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlfg_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_x     <= '0;
      current_y     <= '0;
      target_x      <= '0;
      target_y      <= '0;
      step_sign_x   <= 1'b0;
      step_sign_y   <= 1'b0;
      span_x        <= '0;
      span_y_neg    <= '0;
      error_term    <= '0;
      total_steps   <= '0;
      step_index    <= '0;
      depth_a       <= '0;
      depth_b       <= '0;
      line_color    <= '0;
      brush_half    <= 2'd1;
      line_active   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == tlfg_pkg::BK_EMIT) && fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        tlfg_pkg::BK_IDLE: begin
          if (cmd_valid && (cmd.op == tlfg_pkg::OP_LOAD)) begin
            line_active <= !cmd.reject;
            if (!cmd.reject) begin
              current_x   <= cmd.x0;
              current_y   <= cmd.y0;
              target_x    <= cmd.x1;
              target_y    <= cmd.y1;
              step_sign_x <= cmd.neg_x;
              step_sign_y <= cmd.neg_y;
              span_x      <= cmd.adx;
              span_y_neg  <= 18'(-$signed({1'b0, cmd.ady}));
              error_term  <= 19'($signed({2'b00, cmd.adx}) - $signed({2'b00, cmd.ady}));
              total_steps <= (cmd.adx > cmd.ady) ? cmd.adx : cmd.ady;
              step_index  <= '0;
              depth_a     <= cmd.d0;
              depth_b     <= cmd.d1;
              line_color  <= cmd.color;
              brush_half  <= cmd.half;
            end
          end
        end
        tlfg_pkg::BK_EMIT: begin
          if (fire) begin
            if (last_frag) begin
              if (done_point) begin
                line_active <= 1'b0;
              end else begin
                error_term <= error_term
                            + (take_x ? 19'(span_y_neg) : 19'sd0)
                            + (take_y ? $signed({2'b00, span_x}) : 19'sd0);
                if (take_x) begin
                  current_x <= step_sign_x ? current_x - 16'sd1 : current_x + 16'sd1;
                end
                if (take_y) begin
                  current_y <= step_sign_y ? current_y - 16'sd1 : current_y + 16'sd1;
                end
                if (step_index < total_steps) begin
                  step_index <= step_index + 17'd1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tlfg_pkg::BK_MUL: product <= diff * $signed({1'b0, step_index});
      tlfg_pkg::BK_DIV_START: quot <= '0;
      tlfg_pkg::BK_DIV: begin
        if (div_done) begin
          quot <= div_quotient[18:0];
        end
      end
      tlfg_pkg::BK_SUM: begin
        depth <= 18'({depth_a[17], depth_a} + quot_signed);
        oy    <= -$signed({1'b0, brush_half});
        ox    <= -$signed({1'b0, tlfg_pkg::brush_reach(brush_half, brush_half)});
      end
      tlfg_pkg::BK_EMIT: begin
        if (fire) begin
          out_px    <= ext_x[15:0];
          out_py    <= ext_y[15:0];
          out_depth <= depth;
          out_color <= {line_color[31:8], alpha};
          out_blend <= (alpha != 8'hFF);
          out_fin   <= done_point;
          m_axis_tlast <= last_frag;
          if (ox == $signed({1'b0, reach})) begin
            oy <= oy_inc;
            ox <= -$signed({1'b0, reach_inc});
          end else begin
            ox <= ox + 3'sd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/thick_line_fragment_generator_top.sv */
// A load beat is queued, applied once the back end is idle, and emits nothing.
// A step beat on an active line passes a multiply state, a 35-step bit-serial divider
// for the depth (skipped for a zero-length line) and a sum state, then emits 9, 21 or 37
// fragments into the output register, one a cycle with no output stall; input beats queue.
// Synchronous active-high reset clears the line state, the queue and the output register,
// and sets the frame size to 640 by 480.
module thick_line_fragment_generator_top #(
  parameter int COORD_WIDTH    = 16,
  parameter int MAX_BRUSH_HALF = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [12:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // x_start, y_start, x_end, y_end, depth_start, depth_end, fill_color, stroke width.
  input  logic [143:0] s_axis_tdata,
  // operation.
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_x, pixel_y, pixel_depth, pixel_color.
  output logic [87:0]  m_axis_tdata,
  // blend_enable, line_finished.
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  tlfg_pkg::line_cmd_t cmd;
  logic                cmd_valid;
  logic                cmd_ready;

  tlfg_front #(
    .MAX_BRUSH_HALF (MAX_BRUSH_HALF)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready)
  );

  tlfg_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* tb/thick_line_fragment_checker.sv */
module thick_line_fragment_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [12:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [87:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [17:0] depth;
    logic [31:0]        color;
    logic               blend;
    logic               last;
    logic               finished;
  } fragment_t;

  fragment_t fragment_q[$];

  int frame_w, frame_h;
  int cur_x, cur_y, tgt_x, tgt_y;
  bit neg_x, neg_y;
  int span_x, span_y_neg, err_term, steps_total, step_idx;
  int dep_a, dep_b;
  logic [31:0] colour;
  int half;
  bit active;

  function automatic int fade_factor(int h, int d2);
    if (h == 2) begin
      case (d2)
        0: return 256;
        1: return 162;
        2: return 124;
        4: return 69;
        5: return 47;
        default: return 0;
      endcase
    end
    case (d2)
      0: return 256;
      1: return 187;
      2: return 159;
      4: return 119;
      5: return 103;
      8: return 62;
      9: return 51;
      10: return 40;
      default: return 0;
    endcase
  endfunction

  task automatic load_line(input logic [143:0] d);
    int x0, y0, x1, y1, d0, d1, adx, ady, h;
    x0 = int'($signed(d[15:0]));
    y0 = int'($signed(d[31:16]));
    x1 = int'($signed(d[47:32]));
    y1 = int'($signed(d[63:48]));
    d0 = int'($signed(d[81:64]));
    d1 = int'($signed(d[99:82]));
    adx = x1 > x0 ? x1 - x0 : x0 - x1;
    ady = y1 > y0 ? y1 - y0 : y0 - y1;
    h = int'(d[139:137]);
    active = 0;
    if (longint'(adx) > longint'(frame_w) * 4 ||
        longint'(ady) > longint'(frame_h) * 4) return;
    if (d0 >= 65536 && d1 >= 65536) return;
    cur_x = x0; cur_y = y0; tgt_x = x1; tgt_y = y1;
    neg_x = !(x0 < x1);
    neg_y = !(y0 < y1);
    span_x = adx;
    span_y_neg = -ady;
    err_term = adx - ady;
    steps_total = adx > ady ? adx : ady;
    step_idx = 0;
    dep_a = d0; dep_b = d1;
    colour = d[131:100];
    if (h < 1) h = 1;
    if (h > 3) h = 3;
    half = h;
    active = 1;
  endtask

  task automatic emit_point();
    int depth, d2, a, e2, first;
    longint prod;
    bit done;
    fragment_t f;
    depth = dep_a;
    if (steps_total > 0) begin
      prod = (longint'(dep_b) - longint'(dep_a)) * longint'(step_idx);
      depth = int'(longint'(dep_a) + prod / longint'(steps_total));
    end
    done = (cur_x == tgt_x) && (cur_y == tgt_y);
    first = fragment_q.size();
    for (int oy = -half; oy <= half; oy++) begin
      for (int ox = -half; ox <= half; ox++) begin
        d2 = ox * ox + oy * oy;
        if (d2 <= half * half + half) begin
          a = int'(colour[7:0]);
          if (half > 1) a = (a * fade_factor(half, d2)) >> 8;
          f.px = 16'(cur_x + ox);
          f.py = 16'(cur_y + oy);
          f.depth = 18'(depth);
          f.color = {colour[31:8], 8'(a)};
          f.blend = a < 255;
          f.last = 0;
          f.finished = done;
          fragment_q.push_back(f);
        end
      end
    end
    if (fragment_q.size() > first) fragment_q[fragment_q.size() - 1].last = 1;
    if (done) begin
      active = 0;
    end else begin
      e2 = 2 * err_term;
      if (e2 >= span_y_neg) begin
        err_term += span_y_neg;
        cur_x += neg_x ? -1 : 1;
      end
      if (e2 <= span_x) begin
        err_term += span_x;
        cur_y += neg_y ? -1 : 1;
      end
      if (step_idx < steps_total) step_idx++;
    end
  endtask

  task automatic report(input string what, input fragment_t exp_f, input fragment_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%0t mismatch (%s): expected x=%0d y=%0d z=%0d c=%h b=%b l=%b f=%b,",
                " got x=%0d y=%0d z=%0d c=%h b=%b l=%b f=%b"},
               $realtime, what, exp_f.px, exp_f.py, exp_f.depth, exp_f.color, exp_f.blend,
               exp_f.last, exp_f.finished, got.px, got.py, got.depth, got.color, got.blend,
               got.last, got.finished);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    fragment_t got, exp_f;
    if (rst) begin
      frame_w = 640; frame_h = 480;
      cur_x = 0; cur_y = 0; tgt_x = 0; tgt_y = 0;
      neg_x = 0; neg_y = 0;
      span_x = 0; span_y_neg = 0; err_term = 0; steps_total = 0; step_idx = 0;
      dep_a = 0; dep_b = 0; colour = '0; half = 1; active = 0;
      fragment_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.px = m_axis_tdata[15:0];
        got.py = m_axis_tdata[31:16];
        got.depth = m_axis_tdata[49:32];
        got.color = m_axis_tdata[81:50];
        got.blend = m_axis_tuser[0];
        got.finished = m_axis_tuser[1];
        got.last = m_axis_tlast;
        if (fragment_q.size() == 0) begin
          report("unexpected beat", '0, got);
        end else begin
          exp_f = fragment_q.pop_front();
          if (got !== exp_f) report("field", exp_f, got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tlfg_pkg::REG_FRAME_WIDTH) frame_w = int'(cfg_data);
        else frame_h = int'(cfg_data);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == tlfg_pkg::OP_LOAD) load_line(s_axis_tdata);
        else if (active) emit_point();
      end
    end
    pending = fragment_q.size();
  end

  final begin
  end
endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic         cfg_index = tlfg_pkg::REG_FRAME_WIDTH;
  logic [12:0]  cfg_data = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  // x_start, y_start, x_end, y_end, depth_start, depth_end, fill_color, stroke width.
  logic [143:0] s_axis_tdata = '0;
  // operation.
  logic         s_axis_tuser = tlfg_pkg::OP_LOAD;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  // pixel_x, pixel_y, pixel_depth, pixel_color.
  logic [87:0]  m_axis_tdata;
  // blend_enable, line_finished.
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int fail_count, pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int item_count = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  thick_line_fragment_generator_top dut (.*);

  thick_line_fragment_checker checker_i (.*);

  always @(posedge clk) m_axis_tready <= !rst && ($urandom_range(99) >= stall_pct);

  task automatic send_item(input logic op, input logic [15:0] x0, y0, x1, y1,
                           input logic [17:0] d0, d1, input logic [31:0] col,
                           input logic [7:0] lw);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, lw, col, d1, d0, y1, x1, y0, x0};
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
    item_count++;
  endtask

  task automatic step_point();
    send_item(tlfg_pkg::OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              18'($urandom), 18'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic drain();
    bit ok;
    s_axis_tvalid <= 0;
    do begin
      @(negedge clk);
      ok = (pending == 0);
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic cfg_write(input logic idx, input logic [12:0] val);
    bit ok;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [12:0] w, h);
    drain();
    repeat (100) @(posedge clk);
    cfg_write(tlfg_pkg::REG_FRAME_WIDTH, w);
    cfg_write(tlfg_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic line_and_walk(input logic [15:0] x0, y0, x1, y1, input logic [17:0] d0, d1,
                               input logic [31:0] col, input logic [7:0] lw, input int n);
    send_item(tlfg_pkg::OP_LOAD, x0, y0, x1, y1, d0, d1, col, lw);
    repeat (n) step_point();
  endtask

  task automatic random_group();
    int dx, dy, n, sel;
    logic [15:0] x0, y0;
    logic [17:0] d0, d1;
    sel = $urandom_range(99);
    if (sel < 80) begin
      dx = $urandom_range(24) - 12;
      dy = $urandom_range(24) - 12;
      if ($urandom_range(3) == 0) dx = $urandom_range(4) - 2;
      x0 = 16'($urandom);
      y0 = 16'($urandom);
      if ($urandom_range(1)) begin
        x0 = 16'($urandom_range(200));
        y0 = 16'($urandom_range(200));
      end
      d0 = 18'($urandom);
      d1 = 18'($urandom);
      if ($urandom_range(9) == 0) begin
        d0 = 18'($urandom_range(131071, 65536));
        d1 = 18'($urandom_range(131071, 65536));
      end
      n = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
      n = n + 1;
      if ($urandom_range(6) == 0) n = $urandom_range(n + 3);
      line_and_walk(x0, y0, 16'(x0 + dx), 16'(y0 + dy), d0, d1, $urandom, 8'($urandom), n);
    end else if (sel < 92) begin
      send_item(tlfg_pkg::OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 18'($urandom), 18'($urandom), $urandom, 8'($urandom));
      step_point();
    end else begin
      step_point();
    end
  endtask

  task automatic random_phase(input int quota);
    int stop;
    stop = item_count + quota;
    while (item_count < stop) random_group();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    line_and_walk(16'd10, 16'd10, 16'd14, 16'd12, 18'h20000, 18'h1ffff, 32'h11223344,
                  8'h00, 6);
    line_and_walk(16'd100, 16'd50, 16'd98, 16'd46, 18'h00000, 18'h10000, 32'hffeeddff,
                  8'h40, 5);
    line_and_walk(16'h7fff, 16'h8000, 16'h7ffe, 16'h8001, 18'h0ffff, 18'h3ffff,
                  32'hab0000ff, 8'hff, 2);
    line_and_walk(16'd5, 16'd5, 16'd5, 16'd5, 18'h10000, 18'h00000, 32'h00000080, 8'h3f, 2);
    send_item(tlfg_pkg::OP_LOAD, 16'd0, 16'd0, 16'd3000, 16'd0, 18'd0, 18'd0, 32'hffffffff,
              8'h20);
    step_point();
    send_item(tlfg_pkg::OP_LOAD, 16'd0, 16'd0, 16'd0, 16'd2000, 18'd0, 18'd0, 32'hffffffff,
              8'h20);
    send_item(tlfg_pkg::OP_LOAD, 16'd0, 16'd0, 16'd1, 16'd1, 18'h10000, 18'h10000, 32'h0,
              8'h80);
    step_point();
    send_item(tlfg_pkg::OP_LOAD, 16'd0, 16'd0, 16'd8, 16'd3, 18'h3fff0, 18'h00010,
              32'h55aa5500, 8'h60);
    step_point();
    line_and_walk(16'hfff0, 16'd20, 16'hffee, 16'd17, 18'h12345, 18'h3abcd, 32'h010203fe,
                  8'h7f, 2);

    random_phase(40);

    set_frame(13'd1, 13'd1);
    send_idle_pct = 67;
    random_phase(30);
    drain();
    random_phase(30);

    set_frame(13'd4096, 13'd4096);
    send_idle_pct = 0;
    stall_pct = 67;
    random_phase(55);

    set_frame(13'd0, 13'd8191);
    send_idle_pct = 24;
    stall_pct = 24;
    random_phase(55);

    set_frame(13'd3, 13'd2);
    send_idle_pct = 0;
    stall_pct = 0;
    random_phase(50);

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
